[rtl/waveform_rise_time_meter_defines.svh]
// Assertion macros shared by the rise time meter checkers.
`ifndef WAVEFORM_RISE_TIME_METER_DEFINES_SVH
`define WAVEFORM_RISE_TIME_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rise time meter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rise time meter check failed");

`endif

[rtl/rtm_pkg.sv]
// Types and constants shared by the rise time meter modules.
`default_nettype none
package rtm_pkg;

    localparam int DUR_BITS      = 33;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int CFG_IDX_BIT   = 2;

    localparam int LOW_TH_RESET  = -26214;
    localparam int HIGH_TH_RESET = 26214;

    localparam logic CFG_LOW_IDX  = 1'b0;
    localparam logic CFG_HIGH_IDX = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WRITE,
        S_FINISH
    } t_rtm_state;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic div_sel_hi;
        logic div_write;
        logic finish;
    } t_rtm_cmd;

    typedef struct packed {
        logic lo_div;
        logic hi_div;
        logic waveform_end;
        logic out_busy;
    } t_rtm_status;

endpackage
`default_nettype wire

[rtl/rtm_sample_if.sv]
// Sample request channel: time stamp, value and end-of-waveform flag.
`default_nettype none
interface rtm_sample_if #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [TIME_BITS-1:0]          sample_time;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          waveform_end;

    modport source (output valid, output sample_time, output sample_value,
                    output waveform_end, input ready);
    modport sink   (input valid, input sample_time, input sample_value,
                    input waveform_end, output ready);
endinterface
`default_nettype wire

[rtl/rtm_result_if.sv]
// Result request channel: rise duration and measurement status.
`default_nettype none
interface rtm_result_if;
    import rtm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DUR_BITS-1:0] rise_duration;
    logic                       measure_status;

    modport source (output valid, output rise_duration, output measure_status,
                    input ready);
    modport sink   (input valid, input rise_duration, input measure_status,
                    output ready);
endinterface
`default_nettype wire

[rtl/rtm_cfg.sv]
// APB threshold register file for the rise time meter.
`default_nettype none
module rtm_cfg #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rtm_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [rtm_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [rtm_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    output logic signed [SAMPLE_BITS-1:0]        o_low_th,
    output logic signed [SAMPLE_BITS-1:0]        o_high_th
);
    import rtm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_low_th;
    logic [SAMPLE_BITS-1:0] r_high_th;
    logic                   wr_en;
    logic                   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_IDX_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_th  <= SAMPLE_BITS'(LOW_TH_RESET);
            r_high_th <= SAMPLE_BITS'(HIGH_TH_RESET);
        end else if (wr_en) begin
            case (reg_idx)
                CFG_LOW_IDX:  r_low_th  <= pwdata[SAMPLE_BITS-1:0];
                CFG_HIGH_IDX: r_high_th <= pwdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            CFG_LOW_IDX:  prdata = APB_DATA_BITS'(r_low_th);
            CFG_HIGH_IDX: prdata = APB_DATA_BITS'(r_high_th);
            default:      prdata = '0;
        endcase
    end

    assign o_low_th  = $signed(r_low_th);
    assign o_high_th = $signed(r_high_th);
endmodule
`default_nettype wire

[rtl/rtm_ctrl.sv]
// Sequencer for sample intake, serial interpolation and result hand-off.
`default_nettype none
module rtm_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rtm_pkg::t_rtm_status i_status,
    output rtm_pkg::t_rtm_cmd    o_cmd
);
    import rtm_pkg::*;

    localparam int CW = $clog2(TIME_BITS);
    localparam logic [CW-1:0] LAST_STEP = CW'(TIME_BITS - 1);

    t_rtm_state    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_sel_hi, n_sel_hi;
    logic          r_hi_pend, n_hi_pend;
    logic          r_end, n_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_sel_hi  <= 1'b0;
            r_hi_pend <= 1'b0;
            r_end     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_sel_hi  <= n_sel_hi;
            r_hi_pend <= n_hi_pend;
            r_end     <= n_end;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        n_sel_hi         = r_sel_hi;
        n_hi_pend        = r_hi_pend;
        n_end            = r_end;
        o_cmd            = '0;
        o_cmd.div_sel_hi = r_sel_hi;
        o_ready          = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept   = 1'b1;
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_end          = i_status.waveform_end;
                    n_hi_pend      = i_status.lo_div && i_status.hi_div;
                    n_sel_hi       = !i_status.lo_div;
                    if (i_status.lo_div || i_status.hi_div) begin
                        n_state = S_DIV;
                    end else if (i_status.waveform_end) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.div_write = 1'b1;
                if (r_hi_pend) begin
                    o_cmd.div_init = 1'b1;
                    n_hi_pend      = 1'b0;
                    n_sel_hi       = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else if (r_end) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/rtm_dp.sv]
// Crossing detect, serial shift-subtract interpolator and result register.
`default_nettype none
module rtm_dp #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rtm_pkg::t_rtm_cmd                   i_cmd,
    output rtm_pkg::t_rtm_status                o_status,
    input  logic signed [SAMPLE_BITS-1:0]       i_low_th,
    input  logic signed [SAMPLE_BITS-1:0]       i_high_th,
    input  logic [TIME_BITS-1:0]                i_sample_time,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_value,
    input  logic                                i_waveform_end,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [rtm_pkg::DUR_BITS-1:0] o_rise_duration,
    output logic                                o_measure_status
);
    import rtm_pkg::*;

    localparam int DW   = SAMPLE_BITS;
    localparam int TB   = TIME_BITS;
    localparam int DIFW = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;

    // waveform state
    logic signed [DW-1:0] r_prev_val;
    logic [TB-1:0]        r_prev_time;
    logic                 r_have_prev;
    logic                 r_lo_crossed;
    logic                 r_hi_crossed;
    logic [TB-1:0]        r_lo_time;
    logic [TB-1:0]        r_hi_time;

    // interpolator
    logic [DW-1:0]        r_num_lo;
    logic [DW-1:0]        r_num_hi;
    logic [DW-1:0]        r_den;
    logic [TB-1:0]        r_dt;
    logic [TB-1:0]        r_dt_sh;
    logic [TB-1:0]        r_base;
    logic [DW-1:0]        r_rem;
    logic [TB-1:0]        r_quo;

    // result register
    logic                       r_out_valid;
    logic signed [DUR_BITS-1:0] r_dur;
    logic                       r_status;

    logic signed [DW:0]   lo_num_w, hi_num_w, den_w;
    logic                 lo_hit, hi_hit, lo_div, hi_div, same_val;
    logic [TB-1:0]        dt_in;
    logic [DW-1:0]        num_sel;
    logic [DW:0]          r1, r3;
    logic                 c1, c2;
    logic [DW-1:0]        r2, r4;
    logic [TB-1:0]        quo_nxt;
    logic [TB-1:0]        cross_time;
    logic [DIFW-1:0]      diff;

    assign lo_num_w = (DW+1)'(i_low_th) - (DW+1)'(r_prev_val);
    assign hi_num_w = (DW+1)'(i_high_th) - (DW+1)'(r_prev_val);
    assign den_w    = (DW+1)'(i_sample_value) - (DW+1)'(r_prev_val);
    assign dt_in    = i_sample_time - r_prev_time;
    assign same_val = (i_sample_value == r_prev_val);

    assign lo_hit = r_have_prev && !r_lo_crossed
                    && (r_prev_val <= i_low_th) && (i_sample_value >= i_low_th);
    assign hi_hit = r_have_prev && !r_hi_crossed
                    && (r_prev_val <= i_high_th) && (i_sample_value >= i_high_th);
    assign lo_div = lo_hit && !same_val;
    assign hi_div = hi_hit && !same_val;

    assign o_status.lo_div       = lo_div;
    assign o_status.hi_div       = hi_div;
    assign o_status.waveform_end = i_waveform_end;
    assign o_status.out_busy     = r_out_valid && !i_out_ready;

    // one quotient bit of floor(num * dt / den) per step
    assign num_sel = i_cmd.div_sel_hi ? r_num_hi : r_num_lo;
    assign r1      = {r_rem, 1'b0};
    assign c1      = (r1 >= {1'b0, r_den});
    assign r2      = c1 ? DW'(r1 - {1'b0, r_den}) : DW'(r1);
    assign r3      = {1'b0, r2} + (r_dt_sh[TB-1] ? {1'b0, num_sel} : '0);
    assign c2      = (r3 >= {1'b0, r_den});
    assign r4      = c2 ? DW'(r3 - {1'b0, r_den}) : DW'(r3);
    assign quo_nxt = {r_quo[TB-2:0], 1'b0} + TB'(c1) + TB'(c2);

    assign cross_time = r_base + r_quo;
    assign diff       = DIFW'(r_hi_time) - DIFW'(r_lo_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_lo_crossed <= 1'b0;
            r_hi_crossed <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_have_prev <= 1'b1;
                if (lo_hit) begin
                    r_lo_crossed <= 1'b1;
                end
                if (hi_hit) begin
                    r_hi_crossed <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_have_prev  <= 1'b0;
                r_lo_crossed <= 1'b0;
                r_hi_crossed <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_prev_val  <= i_sample_value;
            r_prev_time <= i_sample_time;
            r_base      <= r_prev_time;
            r_num_lo    <= DW'(lo_num_w);
            r_num_hi    <= DW'(hi_num_w);
            r_den       <= DW'(den_w);
            r_dt        <= dt_in;
            if (lo_hit && same_val) begin
                r_lo_time <= r_prev_time;
            end
            if (hi_hit && same_val) begin
                r_hi_time <= r_prev_time;
            end
        end
        if (i_cmd.div_init) begin
            r_rem   <= '0;
            r_quo   <= '0;
            r_dt_sh <= i_cmd.accept ? dt_in : r_dt;
        end else if (i_cmd.div_step) begin
            r_rem   <= r4;
            r_quo   <= quo_nxt;
            r_dt_sh <= {r_dt_sh[TB-2:0], 1'b0};
        end
        if (i_cmd.div_write) begin
            if (i_cmd.div_sel_hi) begin
                r_hi_time <= cross_time;
            end else begin
                r_lo_time <= cross_time;
            end
        end
        if (i_cmd.finish) begin
            if (r_lo_crossed && r_hi_crossed) begin
                r_dur    <= $signed(diff[DUR_BITS-1:0]);
                r_status <= 1'b0;
            end else begin
                r_dur    <= '0;
                r_status <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rise_duration  = r_dur;
    assign o_measure_status = r_status;
endmodule
`default_nettype wire

[rtl/waveform_rise_time_meter.sv]
// Top level of the waveform rise time meter.
// Takes one sample per cycle while no crossing needs interpolating. A sample that
// makes a first upward crossing between two unequal values holds the input while
// each crossed threshold is interpolated in turn, low first and then high, by the
// single serial shift-subtract interpolator, which yields one quotient bit a cycle.
// The end-of-waveform sample then moves to the finish state, which loads the result
// register once no earlier result is left waiting. The user must write thresholds
// over APB (0x0 low, 0x4 high) only while the block is idle; it does not enforce this.
`default_nettype none
module waveform_rise_time_meter #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rtm_sample_if.sink                        i_sample,
    rtm_result_if.source                      o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rtm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rtm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import rtm_pkg::*;

    t_rtm_cmd                      cmd;
    t_rtm_status                   status;
    logic signed [SAMPLE_BITS-1:0] low_th;
    logic signed [SAMPLE_BITS-1:0] high_th;

    rtm_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_low_th  (low_th),
        .o_high_th (high_th)
    );

    rtm_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sample.valid),
        .o_ready  (i_sample.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rtm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_low_th         (low_th),
        .i_high_th        (high_th),
        .i_sample_time    (i_sample.sample_time),
        .i_sample_value   (i_sample.sample_value),
        .i_waveform_end   (i_sample.waveform_end),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_rise_duration  (o_result.rise_duration),
        .o_measure_status (o_result.measure_status)
    );
endmodule
`default_nettype wire

[rtl/rtm_checker.sv]
// Port-level checks for the rise time meter, bound to the top level.
`default_nettype none
`include "waveform_rise_time_meter_defines.svh"
module rtm_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_in_end,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [rtm_pkg::DUR_BITS-1:0] i_rise_duration,
    input wire logic                                i_measure_status
);
    import rtm_pkg::*;

    `RTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `RTM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_rise_duration) && $stable(i_measure_status))
    `RTM_ASSERT_NEXT(a_end_blocks, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_end, !i_in_ready)
    `RTM_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, i_out_valid && i_measure_status, i_rise_duration == '0)
endmodule

bind waveform_rise_time_meter rtm_checker u_rtm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_sample.valid),
    .i_in_ready       (i_sample.ready),
    .i_in_end         (i_sample.waveform_end),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_rise_duration  (o_result.rise_duration),
    .i_measure_status (o_result.measure_status)
);
`default_nettype wire
